// ===== rtl/swlfd_pkg.sv =====
`default_nettype none

package swlfd_pkg;

    localparam int HEADER_BYTES = 4;
    localparam int CHECK_BYTES  = 2;

    localparam logic [16:0] HDR_LEN17 = 17'(HEADER_BYTES);
    localparam logic [16:0] CHK_LEN17 = 17'(CHECK_BYTES);
    localparam logic [16:0] OVH_LEN17 = 17'(HEADER_BYTES + CHECK_BYTES);

    localparam logic [7:0]  SYNC_FIRST     = 8'hCA;
    localparam logic [7:0]  SYNC_SECOND    = 8'hFE;
    localparam logic [15:0] MAX_LEN_RESET  = 16'd1019;

    localparam logic KIND_CONTENT = 1'b0;
    localparam logic KIND_LEN_ERR = 1'b1;

    localparam logic [1:0] SEC_HEADER  = 2'd0;
    localparam logic [1:0] SEC_PAYLOAD = 2'd1;
    localparam logic [1:0] SEC_CHECK   = 2'd2;

    typedef enum logic [2:0] {
        PH_HUNT    = 3'd0,
        PH_LEN_HI  = 3'd1,
        PH_LEN_LO  = 3'd2,
        PH_HEC     = 3'd3,
        PH_CONTENT = 3'd4
    } t_phase;

    typedef struct packed {
        logic        kind;
        logic [7:0]  out_byte;
        logic [1:0]  section;
        logic [15:0] payload_length;
        logic        last;
    } t_result;

endpackage

`default_nettype wire

// ===== rtl/swlfd_in_stage.sv =====
`default_nettype none

module swlfd_in_stage (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire logic [7:0] i_data_byte,
    input  wire logic       i_can_load,
    output logic            o_advance,
    output logic [7:0]      o_byte
);

    logic       r_valid;
    logic       n_valid;
    logic [7:0] r_byte;
    logic       w_take;

    assign o_advance  = r_valid & i_can_load;
    assign o_in_ready = ~r_valid | i_can_load;
    assign w_take     = i_in_valid & o_in_ready;
    assign o_byte     = r_byte;

    always_comb begin
        n_valid = r_valid;
        if (w_take) begin
            n_valid = 1'b1;
        end else if (o_advance) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_byte <= i_data_byte;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/swlfd_core.sv =====
`default_nettype none

module swlfd_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [15:0] i_cfg_wdata,
    input  wire logic        i_advance,
    input  wire logic [7:0]  i_byte,
    output logic             o_res_valid,
    output swlfd_pkg::t_result o_res
);

    import swlfd_pkg::*;

    t_phase      r_phase;
    t_phase      n_phase;
    logic        r_prev_sync;
    logic        n_prev_sync;
    logic [15:0] r_len;
    logic [15:0] n_len;
    logic [15:0] r_cnt;
    logic [15:0] n_cnt;
    logic [15:0] r_max_len;

    logic [16:0] w_len17;
    logic [16:0] w_cnt17;
    logic        w_last;

    assign w_len17 = {1'b0, r_len};
    assign w_cnt17 = {1'b0, r_cnt};
    assign w_last  = (w_cnt17 + 17'd1) >= w_len17;

    always_comb begin
        n_phase     = r_phase;
        n_prev_sync = r_prev_sync;
        n_len       = r_len;
        n_cnt       = r_cnt;
        o_res_valid = 1'b0;
        o_res       = '0;
        case (r_phase)
            PH_HUNT: begin
                if (r_prev_sync && i_byte == SYNC_SECOND) begin
                    n_prev_sync = 1'b0;
                    n_phase     = PH_LEN_HI;
                end else begin
                    n_prev_sync = (i_byte == SYNC_FIRST);
                end
            end
            PH_LEN_HI: begin
                n_len   = {i_byte, 8'h00};
                n_phase = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                n_len   = r_len | {8'h00, i_byte};
                n_phase = PH_HEC;
            end
            PH_HEC: begin
                if (w_len17 < OVH_LEN17 || r_len > r_max_len) begin
                    o_res_valid = 1'b1;
                    o_res.kind  = KIND_LEN_ERR;
                    n_phase     = PH_HUNT;
                    n_prev_sync = 1'b0;
                    n_len       = '0;
                    n_cnt       = '0;
                end else begin
                    n_cnt   = '0;
                    n_phase = PH_CONTENT;
                end
            end
            PH_CONTENT: begin
                o_res_valid    = 1'b1;
                o_res.kind     = KIND_CONTENT;
                o_res.out_byte = i_byte;
                if (w_cnt17 < HDR_LEN17) begin
                    o_res.section = SEC_HEADER;
                end else if ((w_cnt17 + CHK_LEN17) < w_len17) begin
                    o_res.section = SEC_PAYLOAD;
                end else begin
                    o_res.section = SEC_CHECK;
                end
                o_res.payload_length = 16'(w_len17 - OVH_LEN17);
                o_res.last           = w_last;
                if (w_last) begin
                    n_phase     = PH_HUNT;
                    n_prev_sync = 1'b0;
                    n_len       = '0;
                    n_cnt       = '0;
                end else begin
                    n_cnt = 16'(w_cnt17 + 17'd1);
                end
            end
            default: begin
                n_phase     = PH_HUNT;
                n_prev_sync = 1'b0;
                n_len       = '0;
                n_cnt       = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HUNT;
            r_prev_sync <= 1'b0;
            r_len       <= '0;
            r_cnt       <= '0;
        end else if (i_advance) begin
            r_phase     <= n_phase;
            r_prev_sync <= n_prev_sync;
            r_len       <= n_len;
            r_cnt       <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len <= MAX_LEN_RESET;
        end else if (i_cfg_we) begin
            r_max_len <= i_cfg_wdata;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/swlfd_out_stage.sv =====
`default_nettype none

module swlfd_out_stage (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_advance,
    input  wire logic          i_res_valid,
    input  wire swlfd_pkg::t_result i_res,
    output logic               o_can_load,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output swlfd_pkg::t_result o_res
);

    import swlfd_pkg::*;

    logic    r_valid;
    t_result r_res;
    logic    w_load;

    assign o_can_load  = ~r_valid | i_out_ready;
    assign w_load      = i_advance & i_res_valid;
    assign o_out_valid = r_valid;
    assign o_res       = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_can_load) begin
            r_valid <= w_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_res <= i_res;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/sync_word_length_frame_deframer_unit.sv =====
// Channel | Handshake               | Payload
// in      | i_in_valid / o_in_ready | i_data_byte
// out     | o_out_valid/ i_out_ready| o_out_kind o_out_byte o_section o_payload_length o_last
// cfg     | i_cfg_we                | i_cfg_wdata (max_frame_length)
//
// One request per cycle in while the output is not stalled, at most one result per cycle out.
// An accepted request is held in the input register, then the frame state update
// writes its result into the result register.
// Synchronous active-low reset returns to sync hunt, max length 1019.
// A stalled output holds the result and backs up the input register.
`default_nettype none

module sync_word_length_frame_deframer_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [7:0]  i_data_byte,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic             o_out_kind,
    output logic [7:0]       o_out_byte,
    output logic [1:0]       o_section,
    output logic [15:0]      o_payload_length,
    output logic             o_last,
    input  wire logic        i_cfg_we,
    input  wire logic [15:0] i_cfg_wdata
);

    import swlfd_pkg::*;

    logic       w_can_load;
    logic       w_advance;
    logic [7:0] w_byte;
    logic       w_res_valid;
    t_result    w_res;
    t_result    w_out;

    swlfd_in_stage u_in (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_data_byte (i_data_byte),
        .i_can_load  (w_can_load),
        .o_advance   (w_advance),
        .o_byte      (w_byte)
    );

    swlfd_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_advance   (w_advance),
        .i_byte      (w_byte),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    swlfd_out_stage u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_advance   (w_advance),
        .i_res_valid (w_res_valid),
        .i_res       (w_res),
        .o_can_load  (w_can_load),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_res       (w_out)
    );

    assign o_out_kind       = w_out.kind;
    assign o_out_byte       = w_out.out_byte;
    assign o_section        = w_out.section;
    assign o_payload_length = w_out.payload_length;
    assign o_last           = w_out.last;

endmodule

`default_nettype wire

// ===== rtl/swlfd_checker.sv =====
`default_nettype none

module swlfd_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_out_valid,
    input wire logic        i_out_ready,
    input wire logic        o_out_kind,
    input wire logic [7:0]  o_out_byte,
    input wire logic [1:0]  o_section,
    input wire logic [15:0] o_payload_length,
    input wire logic        o_last
);

    import swlfd_pkg::*;

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_kind)
            && $stable(o_out_byte) && $stable(o_section)
            && $stable(o_payload_length) && $stable(o_last))
        else $error("stalled result changed");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_kind == KIND_LEN_ERR |->
            o_out_byte == 8'h00 && o_section == SEC_HEADER
            && o_payload_length == 16'h0000 && !o_last)
        else $error("length error result carries data");

    a_last_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_kind == KIND_CONTENT && o_last |->
            o_section == SEC_CHECK)
        else $error("last byte not in check section");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind sync_word_length_frame_deframer_unit swlfd_checker u_swlfd_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_out_valid      (o_out_valid),
    .i_out_ready      (i_out_ready),
    .o_out_kind       (o_out_kind),
    .o_out_byte       (o_out_byte),
    .o_section        (o_section),
    .o_payload_length (o_payload_length),
    .o_last           (o_last)
);

`default_nettype wire

// ===== tb/tb_top.sv =====
module tb_top;
    import swlfd_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 8;
    localparam int PHASE_BYTES  = 70;
    localparam int STALL_CYCLES = 300;

    class frame_byte_scoreboard;
        t_phase      phase;
        bit          saw_sync_first;
        logic [15:0] frame_len;
        logic [15:0] byte_idx;
        logic [15:0] max_len;
        t_result     expected_q[$];
        int          fail_count;

        function new();
            max_len    = MAX_LEN_RESET;
            fail_count = 0;
            restart();
        endfunction

        function void restart();
            phase          = PH_HUNT;
            saw_sync_first = 1'b0;
            frame_len      = '0;
            byte_idx       = '0;
        endfunction

        function void set_max(logic [15:0] v);
            max_len = v;
        endfunction

        // advance the deframer state by one accepted request
        function void note_byte(logic [7:0] b);
            t_result r;
            r = '0;
            case (phase)
                PH_HUNT: begin
                    if (saw_sync_first && b == SYNC_SECOND) begin
                        saw_sync_first = 1'b0;
                        phase          = PH_LEN_HI;
                    end else begin
                        saw_sync_first = (b == SYNC_FIRST);
                    end
                end
                PH_LEN_HI: begin
                    frame_len = {b, 8'h00};
                    phase     = PH_LEN_LO;
                end
                PH_LEN_LO: begin
                    frame_len[7:0] = b;
                    phase          = PH_HEC;
                end
                PH_HEC: begin
                    if ({1'b0, frame_len} < OVH_LEN17 || frame_len > max_len) begin
                        r.kind = KIND_LEN_ERR;
                        expected_q.push_back(r);
                        restart();
                    end else begin
                        byte_idx = '0;
                        phase    = PH_CONTENT;
                    end
                end
                PH_CONTENT: begin
                    r.kind     = KIND_CONTENT;
                    r.out_byte = b;
                    if ({1'b0, byte_idx} < HDR_LEN17)
                        r.section = SEC_HEADER;
                    else if ({1'b0, byte_idx} + CHK_LEN17 < {1'b0, frame_len})
                        r.section = SEC_PAYLOAD;
                    else
                        r.section = SEC_CHECK;
                    r.payload_length = frame_len - OVH_LEN17[15:0];
                    r.last = ({1'b0, byte_idx} + 17'd1 >= {1'b0, frame_len});
                    expected_q.push_back(r);
                    if (r.last)
                        restart();
                    else
                        byte_idx = byte_idx + 16'd1;
                end
                default: restart();
            endcase
        endfunction

        task report_mismatch(string what, logic [15:0] got, logic [15:0] exp);
            if (fail_count < 40)
                $display("mismatch %s: got %0h expected %0h", what, got, exp);
            fail_count++;
        endtask

        task check_result(t_result got);
            t_result exp;
            if (expected_q.size() == 0) begin
                report_mismatch("unexpected result", {15'd0, got.kind}, 16'd0);
            end else begin
                exp = expected_q.pop_front();
                if (got.kind != exp.kind)
                    report_mismatch("kind", {15'd0, got.kind}, {15'd0, exp.kind});
                if (got.out_byte != exp.out_byte)
                    report_mismatch("out_byte", {8'd0, got.out_byte}, {8'd0, exp.out_byte});
                if (got.section != exp.section)
                    report_mismatch("section", {14'd0, got.section}, {14'd0, exp.section});
                if (got.payload_length != exp.payload_length)
                    report_mismatch("payload_length", got.payload_length, exp.payload_length);
                if (got.last != exp.last)
                    report_mismatch("last", {15'd0, got.last}, {15'd0, exp.last});
            end
        endtask
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [7:0]  i_data_byte = 8'd0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic        o_out_kind;
    logic [7:0]  o_out_byte;
    logic [1:0]  o_section;
    logic [15:0] o_payload_length;
    logic        o_last;
    logic        i_cfg_we = 1'b0;
    logic [15:0] i_cfg_wdata = 16'd0;

    frame_byte_scoreboard sb = new();

    bit          quiet = 1'b0;
    int          stall_reqs = 0;
    int          sent_count = 0;
    int          cycle_count = 0;
    logic [15:0] cur_max = MAX_LEN_RESET;

    sync_word_length_frame_deframer_unit uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_data_byte      (i_data_byte),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_out_kind       (o_out_kind),
        .o_out_byte       (o_out_byte),
        .o_section        (o_section),
        .o_payload_length (o_payload_length),
        .o_last           (o_last),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata)
    );

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count = cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL sync_word_length_frame_deframer_unit");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready)
                sb.check_result({o_out_kind, o_out_byte, o_section, o_payload_length, o_last});
            if (i_in_valid && o_in_ready)
                sb.note_byte(i_data_byte);
        end
    end

    // result side: random backpressure plus requested long hold-offs
    initial begin
        int stall_left;
        int stall_served;
        stall_left   = 0;
        stall_served = 0;
        forever begin
            @(posedge i_clk);
            if (stall_left == 0 && stall_served != stall_reqs) begin
                stall_served++;
                stall_left = STALL_CYCLES;
            end
            if (stall_left > 0) begin
                stall_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= quiet || ($urandom_range(0, 99) >= 7);
            end
        end
    end

    task automatic send_byte(input logic [7:0] b);
        while (!quiet && $urandom_range(0, 99) < 7) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_data_byte <= b;
        sent_count++;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_max(input logic [15:0] v);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.set_max(v);
        cur_max = v;
    endtask

    task automatic send_frame(input logic [15:0] len);
        send_byte(SYNC_FIRST);
        send_byte(SYNC_SECOND);
        send_byte(len[15:8]);
        send_byte(len[7:0]);
        send_byte(8'($urandom_range(0, 255)));
        if ({1'b0, len} >= OVH_LEN17 && len <= cur_max)
            repeat (len) send_byte(8'($urandom_range(0, 255)));
    endtask

    // inter-frame junk; no sync second byte so framing stays aligned
    task automatic send_noise();
        int n;
        logic [7:0] b;
        n = $urandom_range(0, 3);
        repeat (n) begin
            b = 8'($urandom_range(0, 255));
            if (b == SYNC_SECOND || $urandom_range(0, 3) == 0)
                b = SYNC_FIRST;
            send_byte(b);
        end
    endtask

    function automatic logic [15:0] pick_length();
        int r;
        int m;
        r = $urandom_range(0, 99);
        m = int'(cur_max);
        if (r < 60)
            return (m >= 6 && m < 40) ? 16'($urandom_range(6, m)) : 16'($urandom_range(6, 40));
        if (r < 70 && m <= 64)
            return 16'(m);
        if (r < 78 && m <= 64)
            return 16'(m + 1);
        if (r < 88 || m == 65535)
            return 16'($urandom_range(0, 5));
        return 16'($urandom_range(m + 1, 65535));
    endfunction

    task automatic run_phase();
        int target;
        target = sent_count + PHASE_BYTES;
        while (sent_count < target) begin
            send_noise();
            send_frame(pick_length());
        end
        settle();
    endtask

    initial begin
        logic [7:0]  directed[$];
        logic [15:0] max_settings[6];
        directed = '{8'hCA, 8'h00, 8'hCA, 8'hCA, 8'hFE, 8'h00, 8'h06, 8'h3C,
                     8'h00, 8'hFF, 8'h5A, 8'hA5, 8'h01, 8'h80,
                     8'hCA, 8'hFE, 8'h00, 8'h05, 8'h33,
                     8'hCA, 8'hFE, 8'hFF, 8'hFF, 8'h77};
        max_settings = '{16'hFFFF, 16'h0000, 16'd6, 16'd7, 16'd0, MAX_LEN_RESET};
        max_settings[4] = 16'($urandom_range(8, 50));

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed[i]) send_byte(directed[i]);
        settle();

        // long receiver hold-off while a frame keeps streaming in
        stall_reqs++;
        send_frame(16'd40);
        run_phase();

        foreach (max_settings[i]) begin
            write_max(max_settings[i]);
            quiet = (i == 2);
            run_phase();
        end
        quiet = 1'b0;

        if (sb.fail_count == 0 && sb.expected_q.size() == 0)
            $display("PASS sync_word_length_frame_deframer_unit");
        else
            $display("FAIL sync_word_length_frame_deframer_unit");
        $finish;
    end
endmodule
